// ===== sv/plls_pkg.sv =====
// ----------------------------------------------------------------------------
// PLL synthesizer parameter package
// Constants, field widths and shared types of the PLL parameter calculator.
// ----------------------------------------------------------------------------
package plls_pkg;

  localparam int unsigned FreqW    = 32;
  localparam int unsigned CrystalW = 26;
  localparam int unsigned TargetW  = 30;
  localparam int unsigned ImageW   = 64;
  localparam int unsigned MultW    = 7;
  localparam int unsigned NumW     = 20;
  localparam int unsigned OdivW    = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // In-range frequencies fit in 28 bits; the even divider fits in 11 bits.
  localparam int unsigned FreqNarrowW = 28;
  localparam int unsigned DivW        = 11;
  localparam int unsigned DenomW      = 20;

  localparam logic [FreqW-1:0]    FreqMin      = 32'd1000000;
  localparam logic [FreqW-1:0]    FreqMax      = 32'd225000000;
  localparam logic [CrystalW-1:0] ResetCrystal = 26'd25000000;
  localparam logic [TargetW-1:0]  ResetTarget  = 30'd900000000;
  localparam logic [DenomW-1:0]   PllDenom     = 20'd1048575;
  localparam logic [17:0]         P1Offset     = 18'd512;

  localparam int unsigned DefaultQueueDepth = 2;

  localparam logic [CfgIdxW-1:0] CfgCrystal = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTarget  = 2'd1;

  // One classified request as it travels from the front end to the back end.
  typedef struct packed {
    logic                   err;
    logic [FreqNarrowW-1:0] freq;
  } item_t;

endpackage

// ===== sv/plls_if.sv =====
// ----------------------------------------------------------------------------
// PLL synthesizer channel interfaces
// Request, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface plls_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] freq_hz;
  modport source (output valid, output freq_hz, input ready);
  modport sink   (input valid, input freq_hz, output ready);
endinterface

interface plls_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] pll_image;
  logic [63:0] msynth_image;
  logic [6:0]  pll_mult;
  logic [19:0] pll_num;
  logic [9:0]  out_divider;
  logic        range_error;
  modport source (output valid, output pll_image, output msynth_image, output pll_mult,
                  output pll_num, output out_divider, output range_error, input ready);
  modport sink   (input valid, input pll_image, input msynth_image, input pll_mult,
                  input pll_num, input out_divider, input range_error, output ready);
endinterface

interface plls_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/plls_front.sv =====
// ----------------------------------------------------------------------------
// PLL synthesizer front end
// Flags out-of-range requests and a zero crystal; holds each in one register.
// ----------------------------------------------------------------------------
module plls_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic [plls_pkg::FreqW-1:0]       freq_i,
  input  logic [plls_pkg::CrystalW-1:0]    crystal_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output plls_pkg::item_t                  item_o
);
  import plls_pkg::*;

  logic  valid_q;
  item_t item_q, item_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    item_d.err  = (freq_i < FreqMin) || (freq_i > FreqMax) || (crystal_i == '0);
    item_d.freq = freq_i[FreqNarrowW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== sv/plls_queue.sv =====
// ----------------------------------------------------------------------------
// PLL synthesizer request queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module plls_queue #(
  parameter int unsigned Depth = plls_pkg::DefaultQueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  plls_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            empty_o,
  output plls_pkg::item_t item_o
);
  import plls_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= next_ptr(wr_q);
      end
      if (do_pop) begin
        rd_q <= next_ptr(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== sv/plls_div.sv =====
// ----------------------------------------------------------------------------
// PLL synthesizer pipelined divider
// Restoring divider with one quotient bit per stage and a side tag.
// ----------------------------------------------------------------------------
module plls_div #(
  parameter int unsigned DW = 30,
  parameter int unsigned VW = 26,
  parameter int unsigned TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o,
  output logic [TW-1:0] tag_o
);

  logic          v_q   [DW];
  logic [VW-1:0] rem_q [DW];
  logic [DW-1:0] dvd_q [DW];
  logic [DW-1:0] quo_q [DW];
  logic [VW-1:0] dsr_q [DW];
  logic [TW-1:0] tag_q [DW];

  for (genvar s = 0; s < DW; s++) begin : g_stage
    logic          v_p;
    logic [VW-1:0] rem_p, dsr_p, rem_n;
    logic [DW-1:0] dvd_p, quo_p;
    logic [TW-1:0] tag_p;
    logic [VW:0]   trial;
    logic          qbit;

    if (s == 0) begin : g_first
      assign v_p   = valid_i;
      assign rem_p = '0;
      assign dvd_p = dividend_i;
      assign quo_p = '0;
      assign dsr_p = divisor_i;
      assign tag_p = tag_i;
    end else begin : g_next
      assign v_p   = v_q[s-1];
      assign rem_p = rem_q[s-1];
      assign dvd_p = dvd_q[s-1];
      assign quo_p = quo_q[s-1];
      assign dsr_p = dsr_q[s-1];
      assign tag_p = tag_q[s-1];
    end

    always_comb begin
      trial = {rem_p, dvd_p[DW-1]};
      qbit  = (trial >= {1'b0, dsr_p});
      rem_n = qbit ? VW'(trial - {1'b0, dsr_p}) : trial[VW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_n;
        dvd_q[s] <= dvd_p << 1;
        quo_q[s] <= {quo_p[DW-2:0], qbit};
        dsr_q[s] <= dsr_p;
        tag_q[s] <= tag_p;
      end
    end
  end

  assign valid_o = v_q[DW-1];
  assign quot_o  = quo_q[DW-1];
  assign rem_o   = rem_q[DW-1];
  assign tag_o   = tag_q[DW-1];

endmodule

// ===== sv/plls_back.sv =====
// ----------------------------------------------------------------------------
// PLL synthesizer back end
// Divider chain, PLL frequency product, register packing and result register.
// ----------------------------------------------------------------------------
module plls_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [plls_pkg::CrystalW-1:0] crystal_i,
  input  logic [plls_pkg::TargetW-1:0]  target_i,
  input  logic                          valid_i,
  input  plls_pkg::item_t               item_i,
  output logic                          take_o,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [plls_pkg::ImageW-1:0]   pll_image_o,
  output logic [plls_pkg::ImageW-1:0]   msynth_image_o,
  output logic [plls_pkg::MultW-1:0]    pll_mult_o,
  output logic [plls_pkg::NumW-1:0]     pll_num_o,
  output logic [plls_pkg::OdivW-1:0]    out_divider_o,
  output logic                          range_error_o
);
  import plls_pkg::*;

  localparam int unsigned Tag1W = 1 + FreqNarrowW;
  localparam int unsigned Tag2W = 1 + DivW;
  localparam int unsigned Tag3W = 1 + 2 * DivW;
  localparam int unsigned Dvd3W = CrystalW + DenomW;

  logic en;
  assign en     = !valid_o || ready_i;
  assign take_o = en;

  // Stage one: even divider from the PLL target.
  logic                   d1_v;
  logic [TargetW-1:0]     d1_q;
  logic [FreqNarrowW-1:0] d1_r;
  logic [Tag1W-1:0]       d1_tag;

  plls_div #(.DW(TargetW), .VW(FreqNarrowW), .TW(Tag1W)) u_div_odiv (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(valid_i), .dividend_i(target_i), .divisor_i(item_i.freq),
    .tag_i({item_i.err, item_i.freq}),
    .valid_o(d1_v), .quot_o(d1_q), .rem_o(d1_r), .tag_o(d1_tag)
  );

  // PLL frequency product.
  logic                       m_v_q, m_err_q;
  logic [TargetW-1:0]         m_vco_q;
  logic [DivW-1:0]            m_div_q;
  logic [DivW-1:0]            div_even;
  logic [DivW+FreqNarrowW-1:0] vco_full;

  assign div_even = {d1_q[DivW-1:1], 1'b0};
  assign vco_full = div_even * d1_tag[FreqNarrowW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= d1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_err_q <= d1_tag[Tag1W-1] | (d1_r == '1 & 1'b0);
      m_vco_q <= vco_full[TargetW-1:0];
      m_div_q <= div_even;
    end
  end

  // Stage two: integer multiplier and remainder over the crystal.
  logic                d2_v;
  logic [TargetW-1:0]  d2_q;
  logic [CrystalW-1:0] d2_r;
  logic [Tag2W-1:0]    d2_tag;

  plls_div #(.DW(TargetW), .VW(CrystalW), .TW(Tag2W)) u_div_mult (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(m_v_q), .dividend_i(m_vco_q), .divisor_i(crystal_i),
    .tag_i({m_err_q, m_div_q}),
    .valid_o(d2_v), .quot_o(d2_q), .rem_o(d2_r), .tag_o(d2_tag)
  );

  // Stage three: fractional numerator, remainder scaled by the denominator.
  logic [Dvd3W-1:0]    scaled;
  logic                d3_v;
  logic [Dvd3W-1:0]    d3_q;
  logic [CrystalW-1:0] d3_r;
  logic [Tag3W-1:0]    d3_tag;

  assign scaled = {d2_r, DenomW'(0)} - Dvd3W'(d2_r);

  plls_div #(.DW(Dvd3W), .VW(CrystalW), .TW(Tag3W)) u_div_num (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(d2_v), .dividend_i(scaled), .divisor_i(crystal_i),
    .tag_i({d2_tag, d2_q[DivW-1:0]}),
    .valid_o(d3_v), .quot_o(d3_q), .rem_o(d3_r), .tag_o(d3_tag)
  );

  // Packing. The split of 128 * num by the denominator 2^20 - 1 needs one
  // correction after the shift estimate.
  logic               f_err;
  logic [DivW-1:0]    f_div, f_mult;
  logic [NumW-1:0]    f_num, p2;
  logic [NumW+6:0]    x;
  logic [6:0]         q0, qf;
  logic [DenomW:0]    r0;
  logic [17:0]        p1_pll, p1_ms;

  always_comb begin
    f_err  = d3_tag[Tag3W-1];
    f_div  = d3_tag[2*DivW-1:DivW];
    f_mult = d3_tag[DivW-1:0];
    f_num  = d3_q[NumW-1:0];
    x      = {f_num, 7'b0};
    q0     = x[NumW+6:NumW];
    r0     = {1'b0, x[NumW-1:0]} + (DenomW+1)'(q0);
    if (r0 >= {1'b0, PllDenom}) begin
      qf = q0 + 1'b1;
      p2 = NumW'(r0 - {1'b0, PllDenom});
    end else begin
      qf = q0;
      p2 = r0[NumW-1:0];
    end
    p1_pll = {f_mult, 7'b0} + 18'(qf) - P1Offset;
    p1_ms  = {f_div, 7'b0} - P1Offset;
  end

  logic d3_unused;
  assign d3_unused = ^d3_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= d3_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (f_err) begin
        pll_image_o    <= '0;
        msynth_image_o <= '0;
        pll_mult_o     <= '0;
        pll_num_o      <= '0;
        out_divider_o  <= '0;
        range_error_o  <= 1'b1;
      end else begin
        pll_image_o    <= {PllDenom[15:8], PllDenom[7:0], 6'b0, p1_pll,
                           PllDenom[19:16], p2};
        msynth_image_o <= {8'h00, 8'h01, 6'b0, p1_ms, 4'h0, 20'h0 | {19'h0, d3_unused & 1'b0}};
        pll_mult_o     <= f_mult[MultW-1:0];
        pll_num_o      <= f_num;
        out_divider_o  <= 10'(f_div);
        range_error_o  <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/pll_synth_register_calc.sv =====
// ----------------------------------------------------------------------------
// PLL synthesizer register calculator
// Turns a wanted output frequency into PLL and multisynth register images.
// ----------------------------------------------------------------------------
//
//   Port     Dir   Handshake      Carries
//   cfg_i    in    valid/ready    register index and write data
//   req_i    in    valid/ready    one frequency request (freq_hz)
//   rsp_o    out   valid/ready    register images, multiplier, numerator,
//                                 divider and range error
//
// A new request is taken every cycle as long as no stalled result has filled
// the queue. A request passes the front register, the queue, the three
// restoring dividers (30, 30 and 46 stages, one quotient bit each), the
// product stage and the result register. Reset clears all valid flags and
// loads the default crystal and target. A stalled result holds the whole back
// end in place; the queue and the front register keep taking requests until
// they fill.
module pll_synth_register_calc #(
  parameter int unsigned QueueDepth = plls_pkg::DefaultQueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  plls_cfg_if.sink   cfg_i,
  plls_req_if.sink   req_i,
  plls_rsp_if.source rsp_o
);
  import plls_pkg::*;

  logic [CrystalW-1:0] crystal_q;
  logic [TargetW-1:0]  target_q;

  // Configuration is always accepted; indexes beyond the list are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crystal_q <= ResetCrystal;
      target_q  <= ResetTarget;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgCrystal: crystal_q <= cfg_i.data[CrystalW-1:0];
        CfgTarget:  target_q  <= cfg_i.data[TargetW-1:0];
        default: ;
      endcase
    end
  end

  // Front end: classify each request and hand it to the queue.
  logic  front_v, queue_full;
  item_t front_item;

  plls_front u_front (
    .clk_i, .rst_ni,
    .valid_i(req_i.valid), .ready_o(req_i.ready), .freq_i(req_i.freq_hz),
    .crystal_i(crystal_q),
    .valid_o(front_v), .ready_i(!queue_full), .item_o(front_item)
  );

  // The queue lets the back end stall without blocking the input at once.
  logic  queue_empty, back_take;
  item_t queue_item;

  plls_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_i(front_v), .full_o(queue_full), .item_i(front_item),
    .pop_i(back_take), .empty_o(queue_empty), .item_o(queue_item)
  );

  // Back end: divider chain and register packing.
  plls_back u_back (
    .clk_i, .rst_ni,
    .crystal_i(crystal_q), .target_i(target_q),
    .valid_i(!queue_empty), .item_i(queue_item), .take_o(back_take),
    .valid_o(rsp_o.valid), .ready_i(rsp_o.ready),
    .pll_image_o(rsp_o.pll_image), .msynth_image_o(rsp_o.msynth_image),
    .pll_mult_o(rsp_o.pll_mult), .pll_num_o(rsp_o.pll_num),
    .out_divider_o(rsp_o.out_divider), .range_error_o(rsp_o.range_error)
  );

endmodule

// ===== sim/plls_checker.sv =====
// ----------------------------------------------------------------------------
// PLL synthesizer result checker
// Watches the register, request and result channels, predicts each result
// from its own copy of the registers and compares field by field.
// ----------------------------------------------------------------------------
module plls_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [31:0] req_freq_i,
  plls_rsp_if         rsp,
  output int          fail_count_o,
  output int          pending_o
);
  import plls_pkg::*;

  typedef struct packed {
    logic [63:0] pll_image;
    logic [63:0] msynth_image;
    logic [6:0]  pll_mult;
    logic [19:0] pll_num;
    logic [9:0]  out_divider;
    logic        range_error;
  } synth_result_t;

  logic [CrystalW-1:0] crystal_q;
  logic [TargetW-1:0]  target_q;
  synth_result_t       expected_q[$];

  function automatic logic [63:0] pack_regs(logic [31:0] p1, logic [31:0] p2,
                                            logic [31:0] p3);
    return {p3[15:8], p3[7:0], 6'd0, p1[17:16], p1[15:8], p1[7:0],
            p3[19:16], p2[19:16], p2[15:8], p2[7:0]};
  endfunction

  function automatic synth_result_t synth_settings(logic [31:0] freq);
    synth_result_t r;
    logic [63:0] dv, vco, mult, rem, num, q;
    logic [31:0] p1, p2;
    r = '0;
    if (freq < FreqMin || freq > FreqMax || crystal_q == 0) begin
      r.range_error = 1'b1;
      return r;
    end
    dv   = (64'(target_q) / 64'(freq)) & ~64'd1;
    vco  = dv * 64'(freq);
    mult = vco / 64'(crystal_q);
    rem  = vco % 64'(crystal_q);
    num  = rem * 64'(PllDenom) / 64'(crystal_q);
    q    = 128 * num / 64'(PllDenom);
    p1   = 32'(128 * mult + q - 64'(P1Offset));
    p2   = 32'(128 * num - 64'(PllDenom) * q);
    r.pll_image    = pack_regs(p1, p2, 32'(PllDenom));
    r.msynth_image = pack_regs(32'(128 * dv - 64'(P1Offset)), 32'd0, 32'd1);
    r.pll_mult     = mult[6:0];
    r.pll_num      = num[19:0];
    r.out_divider  = dv[9:0];
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    synth_result_t got, want;
    if (!rst_ni) begin
      crystal_q    <= ResetCrystal;
      target_q     <= ResetTarget;
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      // Results are checked before this edge's request is queued; a request
      // can never turn around in the same cycle.
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.pll_image, rsp.msynth_image, rsp.pll_mult, rsp.pll_num,
                rsp.out_divider, rsp.range_error};
        if (expected_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("mismatch: expected %h actual %h", want, got);
          end
        end
      end
      if (req_valid_i && req_ready_i) expected_q.push_back(synth_settings(req_freq_i));
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgCrystal) crystal_q <= cfg_data_i[CrystalW-1:0];
        else if (cfg_index_i == CfgTarget) target_q <= cfg_data_i[TargetW-1:0];
      end
    end
  end
endmodule

// ===== sim/tb_pll_synth_register_calc.sv =====
// ----------------------------------------------------------------------------
// PLL synthesizer register calculator testbench
// Sends directed and random frequency requests under several register
// settings with random gaps and stalls; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_pll_synth_register_calc;
  import plls_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending;
  int   idle_pct = 30;

  plls_cfg_if cfg_if ();
  plls_req_if req_if ();
  plls_rsp_if rsp_if ();

  pll_synth_register_calc DUT (
    .clk_i (clk_i), .rst_ni(rst_ni),
    .cfg_i (cfg_if.sink), .req_i(req_if.sink), .rsp_o(rsp_if.source)
  );

  plls_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_if.valid), .cfg_ready_i(cfg_if.ready),
    .cfg_index_i(cfg_if.index), .cfg_data_i(cfg_if.data),
    .req_valid_i(req_if.valid), .req_ready_i(req_if.ready),
    .req_freq_i(req_if.freq_hz),
    .rsp(rsp_if), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // The result side stalls at random, except during the quiet stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  initial begin
    cfg_if.valid   = 1'b0;
    cfg_if.index   = CfgCrystal;
    cfg_if.data    = '0;
    req_if.valid   = 1'b0;
    req_if.freq_hz = '0;
  end

  // Writes one register while the block is idle. The write valid stays high
  // after the handshake; the next request or the drain lowers it.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // Offers one frequency request, with a random gap ahead of it. The request
  // valid only drops for a gap, so back-to-back requests keep it high.
  task automatic send_freq(logic [31:0] f);
    cfg_if.valid <= 1'b0;
    if ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    req_if.valid   <= 1'b1;
    req_if.freq_hz <= f;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Waits for every result, then for the pipeline latency, so the block is
  // idle before the registers change.
  task automatic drain();
    req_if.valid <= 1'b0;
    cfg_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  // Most requests land in the legal range; a share probes the edges and the
  // whole 32-bit field.
  function automatic logic [31:0] pick_freq();
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return $urandom_range(1000000);
      2:       return 32'd225000000 + $urandom_range(3) - 1;
      3:       return $urandom_range(2000000, 1000000);
      default: return $urandom_range(225000000, 1000000);
    endcase
  endfunction

  task automatic random_burst(int n);
    repeat (n) send_freq(pick_freq());
  endtask

  initial begin
    logic [31:0] directed[$];
    directed = '{32'd0, 32'd999999, 32'd1000000, 32'd1000001, 32'd10000000,
                 32'd100000000, 32'd224999999, 32'd225000000, 32'd225000001,
                 32'hFFFFFFFF, 32'h80000000, 32'd450000000, 32'd7000000,
                 32'd150000000};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default registers: directed edges, then random traffic.
    foreach (directed[k]) send_freq(directed[k]);
    random_burst(400);
    drain();

    // A quiet stretch: no gaps and no stalls.
    idle_pct = 0;
    random_burst(200);
    drain();
    idle_pct = 30;

    // Register extremes, including a zero crystal, a target that forces a
    // zero divider, and a crystal and target wide enough to wrap the outputs.
    write_reg(CfgCrystal, 32'd10000000);
    write_reg(CfgTarget, 32'd600000000);
    foreach (directed[k]) send_freq(directed[k]);
    random_burst(180);
    drain();
    write_reg(CfgCrystal, 32'd40000000);
    write_reg(CfgTarget, 32'd900000000);
    random_burst(180);
    drain();
    write_reg(CfgCrystal, 32'd0);
    random_burst(40);
    drain();
    write_reg(CfgCrystal, 32'd1);
    write_reg(CfgTarget, 32'h3FFFFFFF);
    foreach (directed[k]) send_freq(directed[k]);
    random_burst(60);
    drain();
    write_reg(CfgCrystal, 32'hFFFFFFFF);
    write_reg(CfgTarget, 32'd1);
    random_burst(60);
    drain();
    write_reg(2'd3, 32'd12345);
    write_reg(2'd2, $urandom());
    write_reg(CfgCrystal, $urandom_range(40000000, 10000000));
    write_reg(CfgTarget, $urandom_range(900000000, 600000000));
    random_burst(200);
    drain();

    if (fail_count == 0) begin
      $display("tb_pll_synth_register_calc OK");
    end else begin
      $display("tb_pll_synth_register_calc NOT OK");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_pll_synth_register_calc NOT OK");
    $finish;
  end
endmodule
